FILE: design/tdn_pkg.sv
// ----------------------------------------------------------------------------
// tdn_pkg: shared definitions for the time-of-day offset normalizer
// Field widths, resolution codes and the control word that travels with
// every item down the pipeline.
// ----------------------------------------------------------------------------
package tdn_pkg;

	// Input field widths.
	localparam int HOUR_W = 16;
	localparam int MIN_W  = 16;
	localparam int SEC_W  = 16;
	localparam int FRAC_W = 32;
	localparam int OFF_W  = 48;

	// Result field widths.
	localparam int HOUR_OUT_W = 5;
	localparam int MIN_OUT_W  = 6;
	localparam int SEC_OUT_W  = 6;
	localparam int FRAC_OUT_W = 20;
	localparam int DAY_NS_W   = 47;

	// Exact signed nanosecond total before wrapping; its magnitude stays below 2^58.
	localparam int TOT_W = 59;

	// Fraction resolution codes.
	localparam logic RES_MS = 1'b0;
	localparam logic RES_US = 1'b1;

	// Control word carried alongside the data of every pipeline stage.
	typedef struct packed {
		logic vld;
		logic res_us;
	} tdn_ctl_t;

endpackage

FILE: design/tdn_scale.sv
// ----------------------------------------------------------------------------
// tdn_scale: scaling and summation stages
// Converts the hour, minute, second, fraction and offset fields to one exact
// signed nanosecond total over three register stages.
// ----------------------------------------------------------------------------
module tdn_scale (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  tdn_pkg::tdn_ctl_t                      in_ctl,
	input  logic signed [tdn_pkg::HOUR_W-1:0]      hour_in,
	input  logic signed [tdn_pkg::MIN_W-1:0]       minute_in,
	input  logic signed [tdn_pkg::SEC_W-1:0]       second_in,
	input  logic signed [tdn_pkg::FRAC_W-1:0]      fraction_in,
	input  logic signed [tdn_pkg::OFF_W-1:0]       offset_us,
	output tdn_pkg::tdn_ctl_t                      out_ctl,
	output logic signed [tdn_pkg::TOT_W-1:0]       total
);
	import tdn_pkg::*;

	// Whole seconds from the h/m/s fields fit 28 signed bits.
	localparam int SSUM_W = 28;
	// Scaled fraction and scaled offset widths.
	localparam int FNS_W  = 52;
	localparam int ONS_W  = 58;

	localparam logic signed [SSUM_W-1:0] SEC_PER_HOUR = 28'sd3600;
	localparam logic signed [SSUM_W-1:0] SEC_PER_MIN  = 28'sd60;
	localparam logic signed [20:0]       NS_PER_MS    = 21'sd1000000;
	localparam logic signed [20:0]       NS_PER_US    = 21'sd1000;
	localparam logic signed [31:0]       NS_PER_SEC   = 32'sd1000000000;

	logic signed [SSUM_W-1:0] sec_sum_d;
	logic signed [20:0]       unit_ns;
	logic signed [FNS_W-1:0]  frac_ns_d;
	logic signed [ONS_W-1:0]  off_ext;
	logic signed [ONS_W-1:0]  off_ns_d;
	logic signed [TOT_W-1:0]  sec_ns_d;
	logic signed [TOT_W-1:0]  sub_ns_d;
	logic signed [TOT_W-1:0]  total_d;

	tdn_ctl_t                 ctl_s1, ctl_s2, ctl_s3;
	logic signed [SSUM_W-1:0] sec_sum_s1;
	logic signed [FNS_W-1:0]  frac_ns_s1;
	logic signed [ONS_W-1:0]  off_ns_s1;
	logic signed [TOT_W-1:0]  sec_ns_s2;
	logic signed [TOT_W-1:0]  sub_ns_s2;
	logic signed [TOT_W-1:0]  total_s3;

	// Stage 1: fold h/m/s into seconds, scale the fraction, scale the offset.
	assign sec_sum_d = SSUM_W'(hour_in) * SEC_PER_HOUR + SSUM_W'(minute_in) * SEC_PER_MIN
		+ SSUM_W'(second_in);
	assign unit_ns   = (in_ctl.res_us == RES_US) ? NS_PER_US : NS_PER_MS;
	assign frac_ns_d = fraction_in * unit_ns;
	// Times 1000 as 1024 - 16 - 8.
	assign off_ext   = ONS_W'(offset_us);
	assign off_ns_d  = (off_ext <<< 10) - (off_ext <<< 4) - (off_ext <<< 3);

	// Stage 2: seconds to nanoseconds, and the sub-second parts summed.
	assign sec_ns_d = sec_sum_s1 * NS_PER_SEC;
	assign sub_ns_d = TOT_W'(frac_ns_s1) + TOT_W'(off_ns_s1);

	// Stage 3: the exact total.
	assign total_d = sec_ns_s2 + sub_ns_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= in_ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		sec_sum_s1 <= sec_sum_d;
		frac_ns_s1 <= frac_ns_d;
		off_ns_s1  <= off_ns_d;
		sec_ns_s2  <= sec_ns_d;
		sub_ns_s2  <= sub_ns_d;
		total_s3   <= total_d;
	end

	assign out_ctl = ctl_s3;
	assign total   = total_s3;

endmodule

FILE: design/tdn_wrap.sv
// ----------------------------------------------------------------------------
// tdn_wrap: wrap into one day
// Non-negative modulo of the signed total by one day over four stages.
// One day is 2^16 * 1318359375 ns, so the low 16 bits pass straight through
// and only the upper part is reduced by a reciprocal estimate and correction.
// ----------------------------------------------------------------------------
module tdn_wrap (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tdn_pkg::tdn_ctl_t                   in_ctl,
	input  logic signed [tdn_pkg::TOT_W-1:0]    total,
	output tdn_pkg::tdn_ctl_t                   out_ctl,
	output logic [tdn_pkg::DAY_NS_W-1:0]        day_ns
);
	import tdn_pkg::*;

	localparam int LO_W   = 16;
	localparam int DIV_W  = 31;
	// Remainder before correction lies in [-DIV, 2*DIV) and fits 33 bits.
	localparam int R_W    = DIV_W + 2;
	// Top bits of the total used for the quotient estimate.
	localparam int EST_W  = 23;
	localparam int RCP_SH = 30;
	localparam int RCP_W  = 21;
	localparam int PRD_W  = EST_W + RCP_W;
	localparam int Q_W    = PRD_W - RCP_SH;

	localparam logic [DIV_W-1:0]        DAY_DIV   = 31'd1318359375;
	localparam logic signed [RCP_W-1:0] DAY_RECIP =
		RCP_W'((64'd1 << (LO_W + EST_W + RCP_SH - EST_W - LO_W + 20)) / 64'd1318359375);

	logic signed [EST_W-1:0] est_top;
	logic signed [PRD_W-1:0] prod_d;
	logic [R_W-1:0]          qc_d;
	logic [R_W-1:0]          r_d;
	logic [R_W-1:0]          rem_fix;

	tdn_ctl_t                ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	logic signed [Q_W-1:0]   qe_s4;
	logic [R_W-1:0]          hi_s4, hi_s5;
	logic [LO_W-1:0]         lo_s4, lo_s5, lo_s6;
	logic [R_W-1:0]          qc_s5;
	logic [R_W-1:0]          r_s6;
	logic [DAY_NS_W-1:0]     day_ns_s7;

	// Stage 4: quotient estimate, within one of the true floor quotient.
	assign est_top = total[TOT_W-1 -: EST_W];
	assign prod_d  = est_top * DAY_RECIP;

	// Stage 5: estimate times divisor, only the low bits that the remainder needs.
	assign qc_d = R_W'(qe_s4) * R_W'(DAY_DIV);

	// Stage 6: raw remainder.
	assign r_d = hi_s5 - qc_s5;

	// Stage 7: bring the remainder into [0, DIV).
	always_comb begin
		if (r_s6[R_W-1]) begin
			rem_fix = r_s6 + R_W'(DAY_DIV);
		end else if (r_s6 >= R_W'(DAY_DIV)) begin
			rem_fix = r_s6 - R_W'(DAY_DIV);
		end else begin
			rem_fix = r_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else begin
			ctl_s4 <= in_ctl;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
		end
	end

	always_ff @(posedge clk) begin
		qe_s4     <= prod_d[PRD_W-1 -: Q_W];
		hi_s4     <= total[LO_W +: R_W];
		lo_s4     <= total[LO_W-1:0];
		qc_s5     <= qc_d;
		hi_s5     <= hi_s4;
		lo_s5     <= lo_s4;
		r_s6      <= r_d;
		lo_s6     <= lo_s5;
		day_ns_s7 <= {rem_fix[DIV_W-1:0], lo_s6};
	end

	assign out_ctl = ctl_s7;
	assign day_ns  = day_ns_s7;

endmodule

FILE: design/tdn_split.sv
// ----------------------------------------------------------------------------
// tdn_split: split the day into fields
// Divides the wrapped day count into seconds and sub-second nanoseconds,
// then into hour, minute, second and truncated fraction, over five stages.
// ----------------------------------------------------------------------------
module tdn_split (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tdn_pkg::tdn_ctl_t                    in_ctl,
	input  logic [tdn_pkg::DAY_NS_W-1:0]         day_ns,
	output tdn_pkg::tdn_ctl_t                    out_ctl,
	output logic [tdn_pkg::HOUR_OUT_W-1:0]       hour_out,
	output logic [tdn_pkg::MIN_OUT_W-1:0]        minute_out,
	output logic [tdn_pkg::SEC_OUT_W-1:0]        second_out,
	output logic [tdn_pkg::FRAC_OUT_W-1:0]       fraction_out,
	output logic [tdn_pkg::DAY_NS_W-1:0]         day_nanoseconds
);
	import tdn_pkg::*;

	// One second is 2^9 * 1953125 ns.
	localparam int           NLO_W   = 9;
	localparam int           SDIV_W  = 21;
	localparam int           XR_W    = SDIV_W + 1;
	localparam int           XH_W    = 22;
	localparam int           SRCP_W  = 24;
	localparam int           SPRD_W  = XH_W + SRCP_W;
	localparam int           SRCP_SH = 28;
	localparam int           DSEC_W  = 17;
	localparam int           SUB_W   = 30;
	localparam int           MT_W    = 11;
	localparam logic [SDIV_W-1:0] SEC_DIV   = 21'd1953125;
	localparam logic [SRCP_W-1:0] SEC_RECIP = SRCP_W'((64'd1 << 44) / 64'd1953125);

	// Exact reciprocals: hour = (sec/16)/225, minutes = (sec/4)/15,
	// ms = (ns/64)/15625, us = (ns/8)/125.
	localparam logic [12:0] HOUR_RECIP = 13'(((64'd1 << 20) + 64'd224) / 64'd225);
	localparam logic [16:0] MIN_RECIP  = 17'(((64'd1 << 20) + 64'd14) / 64'd15);
	localparam logic [24:0] MS_RECIP   = 25'(((64'd1 << 38) + 64'd15624) / 64'd15625);
	localparam logic [27:0] US_RECIP   = 28'(((64'd1 << 34) + 64'd124) / 64'd125);

	localparam logic [MT_W-1:0]   MIN_PER_HOUR = 11'd60;
	localparam logic [DSEC_W-1:0] SEC_PER_MIN  = 17'd60;

	logic [SPRD_W-1:0]      sprod_d;
	logic [XR_W-1:0]        qd_d;
	logic [XR_W-1:0]        r_raw;
	logic                   r_ge;
	logic [XR_W-1:0]        r_fix;
	logic [25:0]            hp_d;
	logic [31:0]            mp_d;
	logic [48:0]            fms_d;
	logic [54:0]            fus_d;
	logic [FRAC_OUT_W-1:0]  frac_d;
	logic [MT_W-1:0]        min_full;
	logic [DSEC_W-1:0]      sec_full;

	tdn_ctl_t               ctl_s8, ctl_s9, ctl_s10, ctl_s11, ctl_s12;
	logic [DSEC_W-1:0]      qs_s8, qs_s9;
	logic [XR_W-1:0]        xlo_s8, xlo_s9;
	logic [NLO_W-1:0]       nlo_s8, nlo_s9;
	logic [DAY_NS_W-1:0]    dns_s8, dns_s9, dns_s10, dns_s11, dns_s12;
	logic [XR_W-1:0]        qd_s9;
	logic [DSEC_W-1:0]      sec_s10, sec_s11;
	logic [SUB_W-1:0]       sub_s10;
	logic [HOUR_OUT_W-1:0]  hour_s11, hour_s12;
	logic [MT_W-1:0]        mint_s11;
	logic [FRAC_OUT_W-1:0]  frac_s11, frac_s12;
	logic [MIN_OUT_W-1:0]   min_s12;
	logic [SEC_OUT_W-1:0]   sec_s12;

	// Stage 8: seconds estimate from the top bits, never above the true value
	// and at most one below it.
	assign sprod_d = day_ns[DAY_NS_W-1 -: XH_W] * SEC_RECIP;

	// Stage 9: estimate times divisor, low bits only.
	assign qd_d = qs_s8 * SEC_DIV;

	// Stage 10: remainder in [0, 2*divisor), then one correction step.
	assign r_raw = xlo_s9 - qd_s9;
	assign r_ge  = (r_raw >= XR_W'(SEC_DIV));
	assign r_fix = r_ge ? (r_raw - XR_W'(SEC_DIV)) : r_raw;

	// Stage 11: hour, total minutes and the truncated fraction.
	assign hp_d  = sec_s10[DSEC_W-1:4] * HOUR_RECIP;
	assign mp_d  = sec_s10[DSEC_W-1:2] * MIN_RECIP;
	assign fms_d = sub_s10[SUB_W-1:6] * MS_RECIP;
	assign fus_d = sub_s10[SUB_W-1:3] * US_RECIP;
	assign frac_d = (ctl_s10.res_us == RES_US) ? fus_d[53:34]
		: FRAC_OUT_W'(fms_d[47:38]);

	// Stage 12: minute of hour and second of minute.
	assign min_full = mint_s11 - MT_W'(hour_s11) * MIN_PER_HOUR;
	assign sec_full = sec_s11 - DSEC_W'(mint_s11) * SEC_PER_MIN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s8  <= '0;
			ctl_s9  <= '0;
			ctl_s10 <= '0;
			ctl_s11 <= '0;
			ctl_s12 <= '0;
		end else begin
			ctl_s8  <= in_ctl;
			ctl_s9  <= ctl_s8;
			ctl_s10 <= ctl_s9;
			ctl_s11 <= ctl_s10;
			ctl_s12 <= ctl_s11;
		end
	end

	always_ff @(posedge clk) begin
		qs_s8    <= sprod_d[SRCP_SH +: DSEC_W];
		xlo_s8   <= day_ns[NLO_W +: XR_W];
		nlo_s8   <= day_ns[NLO_W-1:0];
		dns_s8   <= day_ns;

		qs_s9    <= qs_s8;
		qd_s9    <= qd_d;
		xlo_s9   <= xlo_s8;
		nlo_s9   <= nlo_s8;
		dns_s9   <= dns_s8;

		sec_s10  <= qs_s9 + DSEC_W'(r_ge);
		sub_s10  <= {r_fix[SDIV_W-1:0], nlo_s9};
		dns_s10  <= dns_s9;

		hour_s11 <= hp_d[24:20];
		mint_s11 <= mp_d[30:20];
		frac_s11 <= frac_d;
		sec_s11  <= sec_s10;
		dns_s11  <= dns_s10;

		hour_s12 <= hour_s11;
		min_s12  <= min_full[MIN_OUT_W-1:0];
		sec_s12  <= sec_full[SEC_OUT_W-1:0];
		frac_s12 <= frac_s11;
		dns_s12  <= dns_s11;
	end

	assign out_ctl         = ctl_s12;
	assign hour_out        = hour_s12;
	assign minute_out      = min_s12;
	assign second_out      = sec_s12;
	assign fraction_out    = frac_s12;
	assign day_nanoseconds = dns_s12;

endmodule

FILE: design/time_of_day_offset_normalizer_top.sv
// ----------------------------------------------------------------------------
// time_of_day_offset_normalizer_top: time-of-day normalizer with offset
// Wraps signed h/m/s/fraction fields plus a microsecond offset into one day
// and splits the result back into clock fields.
// ----------------------------------------------------------------------------
// Usage:
//   An item transfers at a rising edge where start is high and busy is low.
//   busy never rises: the twelve-stage pipeline takes one item every cycle,
//   so back-to-back starts sustain one item per clock.
//   Each item produces exactly one result. Its fields are valid while done is
//   high, for exactly one cycle. The receiver cannot stall the block, and
//   none is needed since results leave in order at the rate they enter.
//   The chain of constant multiplies sets the depth: three stages of
//   scaling and summing, four of day wrap, five of splitting.
//   The fraction_resolution register (0 = ms, 1 = us) transfers on the cfg
//   channel whenever cfg_valid is high; cfg_ready is always high. It should
//   only change while no item is in flight. The value in force when an item
//   is taken travels with that item.
//   Reset (arst_n low) clears every stage valid bit and sets the resolution
//   to milliseconds; results in flight are dropped.
// ----------------------------------------------------------------------------
module time_of_day_offset_normalizer_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [tdn_pkg::HOUR_W-1:0]    hour_in,
	input  logic signed [tdn_pkg::MIN_W-1:0]     minute_in,
	input  logic signed [tdn_pkg::SEC_W-1:0]     second_in,
	input  logic signed [tdn_pkg::FRAC_W-1:0]    fraction_in,
	input  logic signed [tdn_pkg::OFF_W-1:0]     offset_us,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_data,
	output logic                                 done,
	output logic [tdn_pkg::HOUR_OUT_W-1:0]       hour_out,
	output logic [tdn_pkg::MIN_OUT_W-1:0]        minute_out,
	output logic [tdn_pkg::SEC_OUT_W-1:0]        second_out,
	output logic [tdn_pkg::FRAC_OUT_W-1:0]       fraction_out,
	output logic [tdn_pkg::DAY_NS_W-1:0]         day_nanoseconds
);
	import tdn_pkg::*;

	// Rising edges from the accepting edge to the edge that takes the result.
	localparam int LATENCY = 12;

	logic                    res_q;
	tdn_ctl_t                in_ctl;
	tdn_ctl_t                scale_ctl;
	tdn_ctl_t                wrap_ctl;
	tdn_ctl_t                split_ctl;
	logic signed [TOT_W-1:0] total;
	logic [DAY_NS_W-1:0]     day_ns;

	// The pipeline never holds off an item, and the register is always writable.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Fraction resolution register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= RES_MS;
		end else if (cfg_valid && cfg_ready) begin
			res_q <= cfg_data;
		end
	end

	// The resolution is sampled with the item so that each result uses the
	// unit in force at the transfer that brought the item in.
	assign in_ctl.vld    = start && !busy;
	assign in_ctl.res_us = res_q;

	tdn_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ctl      (in_ctl),
		.hour_in     (hour_in),
		.minute_in   (minute_in),
		.second_in   (second_in),
		.fraction_in (fraction_in),
		.offset_us   (offset_us),
		.out_ctl     (scale_ctl),
		.total       (total)
	);

	tdn_wrap u_wrap (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (scale_ctl),
		.total   (total),
		.out_ctl (wrap_ctl),
		.day_ns  (day_ns)
	);

	tdn_split u_split (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_ctl          (wrap_ctl),
		.day_ns          (day_ns),
		.out_ctl         (split_ctl),
		.hour_out        (hour_out),
		.minute_out      (minute_out),
		.second_out      (second_out),
		.fraction_out    (fraction_out),
		.day_nanoseconds (day_nanoseconds)
	);

	// The result strobe is the valid bit of the last stage.
	assign done = split_ctl.vld;

	// Every result traces back to a matching earlier input transfer.
	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without a matching input transfer");

	// Wrapped fields must all lie within one day.
	a_fields_in_day: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((hour_out < 5'd24) && (minute_out < 6'd60) && (second_out < 6'd60)
			&& (day_nanoseconds < 47'd86400000000000)))
		else $error("normalized field out of range");

	// A millisecond fraction stays below 1000 and a microsecond one below 1e6.
	a_fraction_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((fraction_out < 20'd1000)
			|| ($past(res_q, LATENCY) && (fraction_out < 20'd1000000))))
		else $error("fraction out of range for its resolution");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for time_of_day_offset_normalizer_top
// Drives signed clock fields and microsecond offsets through the command
// port in random bursts, predicts each wrapped time of day independently,
// and checks every result field as it leaves the pipeline.
// ----------------------------------------------------------------------------
module testbench;
	import tdn_pkg::*;

	// Nanosecond weights of each clock unit.
	localparam longint NS_PER_DAY    = 64'sd86400000000000;
	localparam longint NS_PER_HOUR   = 64'sd3600000000000;
	localparam longint NS_PER_MINUTE = 64'sd60000000000;
	localparam longint NS_PER_SECOND = 64'sd1000000000;
	localparam longint NS_PER_MS     = 64'sd1000000;
	localparam longint NS_PER_US     = 64'sd1000;

	// The limit lies far above what the whole run needs; it only catches a hang.
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_ITEMS   = 100;
	localparam int DRAIN_CYCLES  = 24;
	localparam int REPORT_MAX    = 10;

	// One input item as it is offered on the command port.
	typedef struct {
		logic signed [HOUR_W-1:0] hour;
		logic signed [MIN_W-1:0]  minute;
		logic signed [SEC_W-1:0]  second;
		logic signed [FRAC_W-1:0] fraction;
		logic signed [OFF_W-1:0]  offset;
	} tod_stamp_t;

	// One normalized result as it appears on the result ports.
	typedef struct packed {
		logic [HOUR_OUT_W-1:0] hour;
		logic [MIN_OUT_W-1:0]  minute;
		logic [SEC_OUT_W-1:0]  second;
		logic [FRAC_OUT_W-1:0] fraction;
		logic [DAY_NS_W-1:0]   day_ns;
	} clock_fields_t;

	// Keeps the resolution in force, the queue of predicted clock fields, and
	// the error tally. Results leave in order, so the oldest prediction is
	// always the one the next result must match.
	class clock_field_checker;
		clock_fields_t expected_clock_q[$];
		logic          res_us;
		int            errors;
		int            checked;

		function new();
			res_us  = RES_MS;
			errors  = 0;
			checked = 0;
		endfunction

		function void set_resolution(logic value);
			res_us = value;
		endfunction

		function int pending();
			return expected_clock_q.size();
		endfunction

		// Exact nanosecond sum, true modulo one day, then division into fields.
		// The sum stays below 2^58 in magnitude, so 64-bit arithmetic is exact.
		function void add_timestamp(tod_stamp_t st);
			clock_fields_t wrapped;
			longint        unit_ns;
			longint        total;
			longint        rest;
			unit_ns = (res_us == RES_US) ? NS_PER_US : NS_PER_MS;
			total = longint'(st.hour) * NS_PER_HOUR
			      + longint'(st.minute) * NS_PER_MINUTE
			      + longint'(st.second) * NS_PER_SECOND
			      + longint'(st.fraction) * unit_ns
			      + longint'(st.offset) * NS_PER_US;
			total = total % NS_PER_DAY;
			if (total < 0) begin
				total = total + NS_PER_DAY;
			end
			wrapped.day_ns = total[DAY_NS_W-1:0];
			wrapped.hour   = HOUR_OUT_W'(total / NS_PER_HOUR);
			rest = total % NS_PER_HOUR;
			wrapped.minute = MIN_OUT_W'(rest / NS_PER_MINUTE);
			rest = rest % NS_PER_MINUTE;
			wrapped.second = SEC_OUT_W'(rest / NS_PER_SECOND);
			rest = rest % NS_PER_SECOND;
			wrapped.fraction = FRAC_OUT_W'(rest / unit_ns);
			expected_clock_q.push_back(wrapped);
		endfunction

		function void compare_clock_fields(clock_fields_t got);
			clock_fields_t want;
			checked++;
			if (expected_clock_q.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX) begin
					$display("result %0d arrived with nothing expected: %0d:%0d:%0d.%0d (%0d ns)",
						checked, got.hour, got.minute, got.second, got.fraction, got.day_ns);
				end
				return;
			end
			want = expected_clock_q.pop_front();
			if (got.hour !== want.hour || got.minute !== want.minute ||
			    got.second !== want.second || got.fraction !== want.fraction ||
			    got.day_ns !== want.day_ns) begin
				errors++;
				if (errors <= REPORT_MAX) begin
					$display("result %0d mismatch: expected %0d:%0d:%0d.%0d (%0d ns), got %0d:%0d:%0d.%0d (%0d ns)",
						checked, want.hour, want.minute, want.second, want.fraction, want.day_ns,
						got.hour, got.minute, got.second, got.fraction, got.day_ns);
				end
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic signed [HOUR_W-1:0] hour_in;
	logic signed [MIN_W-1:0]  minute_in;
	logic signed [SEC_W-1:0]  second_in;
	logic signed [FRAC_W-1:0] fraction_in;
	logic signed [OFF_W-1:0]  offset_us;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic                     cfg_data;
	logic                     done;
	logic [HOUR_OUT_W-1:0]    hour_out;
	logic [MIN_OUT_W-1:0]     minute_out;
	logic [SEC_OUT_W-1:0]     second_out;
	logic [FRAC_OUT_W-1:0]    fraction_out;
	logic [DAY_NS_W-1:0]      day_nanoseconds;

	clock_field_checker fields_chk = new();

	int cycle_count = 0;
	int items_sent;
	int burst_left;
	int res_writes;

	time_of_day_offset_normalizer_top u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.hour_in         (hour_in),
		.minute_in       (minute_in),
		.second_in       (second_in),
		.fraction_in     (fraction_in),
		.offset_us       (offset_us),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.done            (done),
		.hour_out        (hour_out),
		.minute_out      (minute_out),
		.second_out      (second_out),
		.fraction_out    (fraction_out),
		.day_nanoseconds (day_nanoseconds)
	);

	// 10 ns clock, starting low so the first rising edge is at 5 ns.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hang guard: counts every cycle of the run and gives up at the limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding",
				cycle_count, fields_chk.pending());
			$display("testbench: FAIL");
			$finish;
		end
	end

	// Result monitor. Sampling at the rising edge sees the values of the cycle
	// that edge ends, which is exactly the cycle the done strobe marks.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) begin
			fields_chk.compare_clock_fields({hour_out, minute_out, second_out,
				fraction_out, day_nanoseconds});
		end
	end

	// Builds an item from its five fields; keeps the directed list readable.
	function automatic tod_stamp_t stamp(longint h, longint m, longint s, longint f,
			longint o);
		tod_stamp_t st;
		st.hour     = h[HOUR_W-1:0];
		st.minute   = m[MIN_W-1:0];
		st.second   = s[SEC_W-1:0];
		st.fraction = f[FRAC_W-1:0];
		st.offset   = o[OFF_W-1:0];
		return st;
	endfunction

	// Random items come in four flavors. The largest share are plausible clock readings with
	// a modest offset, since that is how the block is normally fed. The rest
	// are raw bit patterns (so every input bit toggles), values sitting right
	// on unit and day boundaries, and moderately out-of-range counts that
	// need several carries or borrows.
	function automatic tod_stamp_t random_stamp(logic res_us);
		tod_stamp_t st;
		longint     frac_top;
		int         flavor;
		frac_top = (res_us == RES_US) ? 999999 : 999;
		flavor = $urandom_range(0, 99);
		if (flavor < 40) begin
			st = stamp($urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59),
				$urandom_range(0, int'(frac_top)), 0);
			if ($urandom_range(0, 2) != 0) begin
				st.offset = OFF_W'(longint'($urandom_range(0, 2000000000)) - 1000000000);
			end
		end else if (flavor < 65) begin
			st.hour     = HOUR_W'($urandom);
			st.minute   = MIN_W'($urandom);
			st.second   = SEC_W'($urandom);
			st.fraction = FRAC_W'($urandom);
			st.offset   = OFF_W'({$urandom, $urandom});
		end else if (flavor < 85) begin
			case ($urandom_range(0, 5))
				0: st.hour = -1;
				1: st.hour = 0;
				2: st.hour = 23;
				3: st.hour = 24;
				4: st.hour = -24;
				default: st.hour = 48;
			endcase
			case ($urandom_range(0, 3))
				0: st.minute = -1;
				1: st.minute = 0;
				2: st.minute = 59;
				default: st.minute = 60;
			endcase
			case ($urandom_range(0, 3))
				0: st.second = -1;
				1: st.second = 0;
				2: st.second = 59;
				default: st.second = 60;
			endcase
			case ($urandom_range(0, 3))
				0: st.fraction = -1;
				1: st.fraction = 0;
				2: st.fraction = FRAC_W'(frac_top);
				default: st.fraction = FRAC_W'(frac_top + 1);
			endcase
			case ($urandom_range(0, 5))
				0: st.offset = 0;
				1: st.offset = -1;
				2: st.offset = 1;
				3: st.offset = OFF_W'(64'sd86400000000);
				4: st.offset = OFF_W'(-64'sd86400000000);
				default: st.offset = 0;
			endcase
		end else begin
			st = stamp(longint'($urandom_range(0, 200)) - 100,
				longint'($urandom_range(0, 2000)) - 1000,
				longint'($urandom_range(0, 20000)) - 10000,
				longint'($urandom_range(0, 4000000)) - 2000000,
				longint'($urandom) - longint'($urandom));
		end
		return st;
	endfunction

	// Offers one item and waits for the transfer. The sender works in bursts:
	// when the current burst runs out, start drops for a random gap. A burst
	// that continues leaves start high, so the next call only moves the fields.
	task automatic send_item(input tod_stamp_t st);
		int gap;
		start       <= 1'b1;
		hour_in     <= st.hour;
		minute_in   <= st.minute;
		second_in   <= st.second;
		fraction_in <= st.fraction;
		offset_us   <= st.offset;
		do @(posedge clk); while (busy !== 1'b0);
		fields_chk.add_timestamp(st);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
			// Occasional long bursts give stretches with no idling at all.
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
			                                        : $urandom_range(1, 8);
		end
	endtask

	// Stops offering items and waits until every predicted result has come
	// out. Every item yields a result, so an empty queue means an idle block.
	task automatic drain_pipeline();
		start <= 1'b0;
		while (fields_chk.pending() != 0) @(posedge clk);
	endtask

	// Writes the resolution register; only called with the pipeline drained.
	task automatic write_resolution(input logic value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		fields_chk.set_resolution(value);
		res_writes++;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		tod_stamp_t directed_ms[$];
		tod_stamp_t directed_us[$];
		logic       phase_res;

		// Every input known from time zero; reset held low at the start.
		clk         = 1'b0;
		arst_n      = 1'b0;
		start       = 1'b0;
		hour_in     = '0;
		minute_in   = '0;
		second_in   = '0;
		fraction_in = '0;
		offset_us   = '0;
		cfg_valid   = 1'b0;
		cfg_data    = 1'b0;
		items_sent  = 0;
		res_writes  = 0;
		burst_left  = $urandom_range(1, 8);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at the reset resolution (milliseconds): all zero, every
		// field at its top and bottom, exact day wraps in both directions, the
		// last tick before midnight, and totals that go negative by one unit.
		directed_ms.push_back(stamp(0, 0, 0, 0, 0));
		directed_ms.push_back(stamp(32767, 32767, 32767, 2147483647, 64'sd140737488355327));
		directed_ms.push_back(stamp(-32768, -32768, -32768, -2147483648,
			-64'sd140737488355328));
		directed_ms.push_back(stamp(24, 0, 0, 0, 0));
		directed_ms.push_back(stamp(-1, 0, 0, 0, 0));
		directed_ms.push_back(stamp(0, 0, 0, -1, 0));
		directed_ms.push_back(stamp(0, 0, 0, 0, -1));
		directed_ms.push_back(stamp(23, 59, 59, 999, 0));
		directed_ms.push_back(stamp(0, 0, 0, 0, 1));
		directed_ms.push_back(stamp(32767, -32768, 0, 0, 0));
		directed_ms.push_back(stamp(0, 0, 0, 0, -64'sd86400000000));
		directed_ms.push_back(stamp(0, 0, 0, 2147483647, 0));
		foreach (directed_ms[i]) send_item(directed_ms[i]);
		drain_pipeline();

		// Same corners again with microsecond resolution, plus a fraction that
		// carries exactly one second and a full-precision reading.
		write_resolution(RES_US);
		directed_us.push_back(stamp(0, 0, 0, 0, 0));
		directed_us.push_back(stamp(0, 0, 0, 999999, 0));
		directed_us.push_back(stamp(0, 0, 59, 1000000, 0));
		directed_us.push_back(stamp(0, 0, 0, -1, 0));
		directed_us.push_back(stamp(0, 0, 0, 0, -1));
		directed_us.push_back(stamp(32767, 32767, 32767, 2147483647, 64'sd140737488355327));
		directed_us.push_back(stamp(-32768, -32768, -32768, -2147483648,
			-64'sd140737488355328));
		directed_us.push_back(stamp(12, 34, 56, 123456, 0));
		directed_us.push_back(stamp(0, -1440, 0, 0, 64'sd86400000000));
		directed_us.push_back(stamp(0, 0, 0, -2147483648, 0));
		foreach (directed_us[i]) send_item(directed_us[i]);
		drain_pipeline();

		// Random phases, flipping the resolution between them. The register is
		// rewritten at the start of every phase, only once the pipe is empty.
		phase_res = RES_US;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			phase_res = (phase_res == RES_US) ? RES_MS : RES_US;
			write_resolution(phase_res);
			for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_stamp(phase_res));
			drain_pipeline();
		end

		// Let any stray strobe show up before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d items (%0d directed) across %0d resolution writes in %0d cycles",
			items_sent, directed_ms.size() + directed_us.size(), res_writes, cycle_count);
		$display("checked %0d results, %0d errors, %0d still expected",
			fields_chk.checked, fields_chk.errors, fields_chk.pending());
		if (fields_chk.errors == 0 && fields_chk.pending() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/tdn_pkg.sv
design/tdn_scale.sv
design/tdn_wrap.sv
design/tdn_split.sv
design/time_of_day_offset_normalizer_top.sv
sim/testbench.sv
